/* rtl/ffa_pkg.sv */
`default_nettype none
package ffa_pkg;

  localparam int DESCRIPTORS = 64;
  localparam int OFF_W       = 24;
  localparam int ADDR_W      = $clog2(DESCRIPTORS);
  localparam int LINK_W      = $clog2(DESCRIPTORS + 1);
  localparam int SIZE_W      = OFF_W + 1;
  localparam int CELL_W      = 13;
  localparam int CNT_W       = $clog2(OFF_W);
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_W       = 24;

  localparam logic [LINK_W-1:0] NIL = LINK_W'(DESCRIPTORS);

  localparam logic [CELL_W-1:0] CELL_RESET  = CELL_W'(16);
  localparam logic [OFF_W-1:0]  TOTAL_RESET = OFF_W'(65536);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_ZERO     = 3'd1,
    STAT_NOFIT    = 3'd2,
    STAT_NODESC   = 3'd3,
    STAT_RANGE    = 3'd4,
    STAT_NOTALLOC = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CELL  = 1'b0,
    CFG_TOTAL = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [OFF_W-1:0]  offset;
    logic [OFF_W-1:0]  length;
    logic              free;
    logic [LINK_W-1:0] aprev;
    logic [LINK_W-1:0] anext;
    logic [LINK_W-1:0] lprev;
    logic [LINK_W-1:0] lnext;
  } desc_t;

  typedef enum logic [5:0] {
    STEP_INIT,
    STEP_IDLE,
    STEP_DECODE,
    STEP_DIV,
    STEP_A_RD,
    STEP_A_CHK,
    STEP_X_P_RD,
    STEP_X_P_WR,
    STEP_X_N_RD,
    STEP_X_N_WR,
    STEP_X_H_RD,
    STEP_X_H_WR,
    STEP_X_E_WR,
    STEP_S_P_RD,
    STEP_S_P_WR,
    STEP_S_H_RD,
    STEP_S_H_WR,
    STEP_S_E_WR,
    STEP_S_D_WR,
    STEP_F_RD,
    STEP_F_CHK,
    STEP_F_P_RD,
    STEP_F_P_WR,
    STEP_F_N_RD,
    STEP_F_N_WR,
    STEP_F_AP_RD,
    STEP_F_AP_CHK,
    STEP_F_AN_RD,
    STEP_F_AN_WR,
    STEP_F_NX_RD,
    STEP_F_NX_CHK,
    STEP_F_UP_RD,
    STEP_F_UP_WR,
    STEP_F_UN_RD,
    STEP_F_UN_WR,
    STEP_F_Q_RD,
    STEP_F_Q_WR,
    STEP_F_M_RD,
    STEP_F_M_WR,
    STEP_F_H_RD,
    STEP_F_H_WR,
    STEP_F_E_WR,
    STEP_CLR,
    STEP_RESP
  } step_t;

  typedef struct packed {
    step_t step;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic req_zero;
    logic off_range;
    logic div_done;
    logic fh_nil;
    logic lh_nil;
    logic fit;
    logic exact;
    logic no_spare;
    logic walk_end;
    logic hit;
    logic lprev_nil;
    logic lnext_nil;
    logic aprev_nil;
    logic anext_nil;
    logic rd_free;
    logic merged;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

/* rtl/ffa_req_if.sv */
`default_nettype none
interface ffa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [23:0] request_size;
  logic [23:0] release_offset;

  modport source (output valid, op, request_size, release_offset, input ready);
  modport sink (input valid, op, request_size, release_offset, output ready);
endinterface
`default_nettype wire

/* rtl/ffa_rsp_if.sv */
`default_nettype none
interface ffa_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [23:0] grant_offset;
  logic [23:0] granted_size;
  logic [23:0] locked_bytes;

  modport source (output valid, status, grant_offset, granted_size, locked_bytes,
                  input ready);
  modport sink (input valid, status, grant_offset, granted_size, locked_bytes,
                output ready);
endinterface
`default_nettype wire

/* rtl/ffa_ctrl.sv */
`default_nettype none
module ffa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  ffa_pkg::sts_t sts,
  output ffa_pkg::cmd_t cmd
);
  import ffa_pkg::*;

  step_t step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_INIT;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    step_next = step;
    unique case (step)
      STEP_INIT:   step_next = STEP_IDLE;
      STEP_IDLE:   if (in_valid) step_next = STEP_DECODE;
      STEP_DECODE: begin
        unique case (sts.op)
          OP_ALLOC: step_next = sts.req_zero ? STEP_RESP : STEP_DIV;
          OP_FREE:  step_next = sts.off_range ? STEP_RESP : STEP_F_RD;
          OP_CLEAR: step_next = STEP_CLR;
          default:  step_next = STEP_RESP;
        endcase
      end
      STEP_DIV:    if (sts.div_done) step_next = STEP_A_RD;
      STEP_A_RD:   step_next = sts.fh_nil ? STEP_RESP : STEP_A_CHK;
      STEP_A_CHK: begin
        if (sts.fit) begin
          if (sts.exact) step_next = STEP_X_P_RD;
          else step_next = sts.no_spare ? STEP_RESP : STEP_S_P_RD;
        end else if (sts.walk_end) begin
          step_next = STEP_RESP;
        end
      end
      STEP_X_P_RD: step_next = sts.lprev_nil ? STEP_X_N_RD : STEP_X_P_WR;
      STEP_X_P_WR: step_next = STEP_X_N_RD;
      STEP_X_N_RD: step_next = sts.lnext_nil ? STEP_X_H_RD : STEP_X_N_WR;
      STEP_X_N_WR: step_next = STEP_X_H_RD;
      STEP_X_H_RD: step_next = sts.lh_nil ? STEP_X_E_WR : STEP_X_H_WR;
      STEP_X_H_WR: step_next = STEP_X_E_WR;
      STEP_X_E_WR: step_next = STEP_RESP;
      STEP_S_P_RD: step_next = sts.aprev_nil ? STEP_S_H_RD : STEP_S_P_WR;
      STEP_S_P_WR: step_next = STEP_S_H_RD;
      STEP_S_H_RD: step_next = sts.lh_nil ? STEP_S_E_WR : STEP_S_H_WR;
      STEP_S_H_WR: step_next = STEP_S_E_WR;
      STEP_S_E_WR: step_next = STEP_S_D_WR;
      STEP_S_D_WR: step_next = STEP_RESP;
      STEP_F_RD:   step_next = sts.lh_nil ? STEP_RESP : STEP_F_CHK;
      STEP_F_CHK: begin
        if (sts.hit) step_next = STEP_F_P_RD;
        else if (sts.walk_end) step_next = STEP_RESP;
      end
      STEP_F_P_RD:   step_next = sts.lprev_nil ? STEP_F_N_RD : STEP_F_P_WR;
      STEP_F_P_WR:   step_next = STEP_F_N_RD;
      STEP_F_N_RD:   step_next = sts.lnext_nil ? STEP_F_AP_RD : STEP_F_N_WR;
      STEP_F_N_WR:   step_next = STEP_F_AP_RD;
      STEP_F_AP_RD:  step_next = sts.aprev_nil ? STEP_F_NX_RD : STEP_F_AP_CHK;
      STEP_F_AP_CHK: begin
        if (sts.rd_free && !sts.anext_nil) step_next = STEP_F_AN_RD;
        else step_next = STEP_F_NX_RD;
      end
      STEP_F_AN_RD:  step_next = STEP_F_AN_WR;
      STEP_F_AN_WR:  step_next = STEP_F_NX_RD;
      STEP_F_NX_RD: begin
        if (!sts.anext_nil) step_next = STEP_F_NX_CHK;
        else step_next = sts.merged ? STEP_F_E_WR : STEP_F_H_RD;
      end
      STEP_F_NX_CHK: begin
        if (sts.rd_free) step_next = sts.merged ? STEP_F_UP_RD : STEP_F_Q_RD;
        else step_next = sts.merged ? STEP_F_E_WR : STEP_F_H_RD;
      end
      STEP_F_UP_RD: step_next = sts.lprev_nil ? STEP_F_UN_RD : STEP_F_UP_WR;
      STEP_F_UP_WR: step_next = STEP_F_UN_RD;
      STEP_F_UN_RD: step_next = sts.lnext_nil ? STEP_F_Q_RD : STEP_F_UN_WR;
      STEP_F_UN_WR: step_next = STEP_F_Q_RD;
      STEP_F_Q_RD:  step_next = sts.aprev_nil ? STEP_F_M_RD : STEP_F_Q_WR;
      STEP_F_Q_WR:  step_next = STEP_F_M_RD;
      STEP_F_M_RD:  step_next = STEP_F_M_WR;
      STEP_F_M_WR:  step_next = STEP_RESP;
      STEP_F_H_RD:  step_next = sts.fh_nil ? STEP_F_E_WR : STEP_F_H_WR;
      STEP_F_H_WR:  step_next = STEP_F_E_WR;
      STEP_F_E_WR:  step_next = STEP_RESP;
      STEP_CLR:     step_next = STEP_RESP;
      STEP_RESP:    if (sts.out_free) step_next = STEP_IDLE;
      default:      step_next = STEP_IDLE;
    endcase
  end

  always_comb begin
    cmd.step = step;
  end

endmodule
`default_nettype wire

/* rtl/ffa_dp.sv */
`default_nettype none
module ffa_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  ffa_pkg::cmd_t                      cmd,
  output ffa_pkg::sts_t                      sts,
  input  logic                               in_accept,
  input  logic [1:0]                         in_op,
  input  logic [ffa_pkg::OFF_W-1:0]          in_request_size,
  input  logic [ffa_pkg::OFF_W-1:0]          in_release_offset,
  input  logic                               cfg_we,
  input  logic [ffa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ffa_pkg::CFG_W-1:0]          cfg_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [2:0]                         out_status,
  output logic [ffa_pkg::OFF_W-1:0]          out_grant_offset,
  output logic [ffa_pkg::OFF_W-1:0]          out_granted_size,
  output logic [ffa_pkg::OFF_W-1:0]          out_locked_bytes
);
  import ffa_pkg::*;

  desc_t mem [DESCRIPTORS];
  desc_t rdata;
  desc_t wd;
  logic  we;
  logic [ADDR_W-1:0] wa;
  logic [LINK_W-1:0] rd_addr;
  logic [ADDR_W-1:0] tgt;

  logic [CELL_W-1:0]  cs;
  logic [OFF_W-1:0]   ts;
  logic [LINK_W-1:0]  fh;
  logic [LINK_W-1:0]  lh;
  logic [ADDR_W-1:0]  fs;
  logic [DESCRIPTORS-1:0] spare;
  logic [OFF_W-1:0]   lt;

  op_t               op;
  logic [OFF_W-1:0]  rsize;
  logic [OFF_W-1:0]  roff;
  logic [CELL_W-1:0] rem;
  logic [CNT_W-1:0]  cnt;
  logic [SIZE_W-1:0] size;
  logic [ADDR_W-1:0] steps;
  logic [LINK_W-1:0] cur;
  desc_t             ecur;
  logic [ADDR_W-1:0] eidx;
  logic [ADDR_W-1:0] d;
  logic [ADDR_W-1:0] nidx;
  logic              merged;
  status_t           res_status;
  logic [OFF_W-1:0]  res_off;
  logic [OFF_W-1:0]  res_sz;

  logic [CELL_W-1:0] cs_eff;
  logic [CELL_W:0]   shifted;
  logic [CELL_W-1:0] rem_next;
  logic [SIZE_W-1:0] size_calc;
  logic [ADDR_W-1:0] spare_idx;
  logic              out_free;
  logic              cfg_total;
  logic              walk_end;

  function automatic logic [ADDR_W-1:0] lowest_set(input logic [DESCRIPTORS-1:0] m);
    logic [ADDR_W-1:0] r;
    r = '0;
    for (int i = DESCRIPTORS - 1; i >= 0; i--) begin
      if (m[i]) r = ADDR_W'(i);
    end
    return r;
  endfunction

  assign cs_eff    = (cs == '0) ? CELL_W'(1) : cs;
  assign shifted   = {rem, rsize[cnt]};
  assign rem_next  = (shifted >= {1'b0, cs_eff}) ? CELL_W'(shifted - {1'b0, cs_eff})
                                                 : shifted[CELL_W-1:0];
  assign size_calc = (rem != '0) ? ({1'b0, rsize} + SIZE_W'(cs_eff) - SIZE_W'(rem))
                                 : {1'b0, rsize};
  assign spare_idx = lowest_set(spare);
  assign out_free  = !out_valid || out_ready;
  assign cfg_total = cfg_we && (cfg_reg_t'(cfg_index) == CFG_TOTAL);
  assign walk_end  = (rdata.lnext == NIL) || (steps == ADDR_W'(DESCRIPTORS - 1));

  always_comb begin
    sts.op        = op;
    sts.req_zero  = (rsize == '0);
    sts.off_range = (roff > ts);
    sts.div_done  = (cnt == '0);
    sts.fh_nil    = (fh == NIL);
    sts.lh_nil    = (lh == NIL);
    sts.fit       = ({1'b0, rdata.length} >= size);
    sts.exact     = ({1'b0, rdata.length} == size);
    sts.no_spare  = (spare == '0);
    sts.walk_end  = walk_end;
    sts.hit       = (rdata.offset == roff);
    sts.lprev_nil = (ecur.lprev == NIL);
    sts.lnext_nil = (ecur.lnext == NIL);
    sts.aprev_nil = (ecur.aprev == NIL);
    sts.anext_nil = (ecur.anext == NIL);
    sts.rd_free   = rdata.free;
    sts.merged    = merged;
    sts.out_free  = out_free;
  end

  // Memory port: one read address and one record write per cycle.
  always_comb begin
    rd_addr = '0;
    we      = 1'b0;
    wa      = tgt;
    wd      = rdata;
    unique case (cmd.step)
      STEP_INIT, STEP_CLR: begin
        we = 1'b1;
        wa = fs;
        wd = '{offset: '0, length: ts, free: 1'b1,
               aprev: NIL, anext: NIL, lprev: NIL, lnext: NIL};
      end
      STEP_IDLE: begin
        if (cfg_total) begin
          we = 1'b1;
          wa = fs;
          wd = '{offset: '0, length: OFF_W'(cfg_data), free: 1'b1,
                 aprev: NIL, anext: NIL, lprev: NIL, lnext: NIL};
        end
      end
      STEP_A_RD:    rd_addr = fh;
      STEP_A_CHK:   rd_addr = rdata.lnext;
      STEP_X_P_RD, STEP_F_P_RD, STEP_F_UP_RD: rd_addr = ecur.lprev;
      STEP_X_N_RD, STEP_F_N_RD, STEP_F_UN_RD: rd_addr = ecur.lnext;
      STEP_X_H_RD, STEP_S_H_RD, STEP_F_RD:   rd_addr = lh;
      STEP_S_P_RD, STEP_F_AP_RD, STEP_F_Q_RD: rd_addr = ecur.aprev;
      STEP_F_AN_RD, STEP_F_NX_RD:            rd_addr = ecur.anext;
      STEP_F_CHK:   rd_addr = rdata.lnext;
      STEP_F_M_RD:  rd_addr = LINK_W'(nidx);
      STEP_F_H_RD:  rd_addr = fh;
      STEP_X_P_WR, STEP_F_P_WR, STEP_F_UP_WR: begin
        we = 1'b1;
        wd.lnext = ecur.lnext;
      end
      STEP_X_N_WR, STEP_F_N_WR, STEP_F_UN_WR: begin
        we = 1'b1;
        wd.lprev = ecur.lprev;
      end
      STEP_X_H_WR, STEP_F_H_WR: begin
        we = 1'b1;
        wd.lprev = LINK_W'(eidx);
      end
      STEP_X_E_WR: begin
        we = 1'b1;
        wa = eidx;
        wd = ecur;
        wd.free  = 1'b0;
        wd.lprev = NIL;
        wd.lnext = lh;
      end
      STEP_S_P_WR: begin
        we = 1'b1;
        wd.anext = LINK_W'(d);
      end
      STEP_S_H_WR: begin
        we = 1'b1;
        wd.lprev = LINK_W'(d);
      end
      STEP_S_E_WR: begin
        we = 1'b1;
        wa = eidx;
        wd = ecur;
        wd.aprev  = LINK_W'(d);
        wd.offset = ecur.offset + size[OFF_W-1:0];
        wd.length = ecur.length - size[OFF_W-1:0];
      end
      STEP_S_D_WR: begin
        we = 1'b1;
        wa = d;
        wd = '{offset: ecur.offset, length: size[OFF_W-1:0], free: 1'b0,
               aprev: ecur.aprev, anext: LINK_W'(eidx), lprev: NIL, lnext: lh};
      end
      STEP_F_AN_WR: begin
        we = 1'b1;
        wd.aprev = LINK_W'(eidx);
      end
      STEP_F_Q_WR: begin
        we = 1'b1;
        wd.anext = LINK_W'(nidx);
      end
      STEP_F_M_WR: begin
        we = 1'b1;
        wa = nidx;
        wd.aprev  = ecur.aprev;
        wd.length = rdata.length + ecur.length;
        wd.offset = ecur.offset;
      end
      STEP_F_E_WR: begin
        we = 1'b1;
        wa = eidx;
        wd = ecur;
        if (!merged) begin
          wd.free  = 1'b1;
          wd.lprev = NIL;
          wd.lnext = fh;
        end
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rdata <= mem[rd_addr[ADDR_W-1:0]];
    tgt   <= rd_addr[ADDR_W-1:0];
  end

  // Control and table state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cs        <= CELL_RESET;
      ts        <= TOTAL_RESET;
      fh        <= '0;
      lh        <= NIL;
      fs        <= '0;
      spare     <= '1;
      lt        <= '0;
      merged    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.step == STEP_RESP && out_free) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (cmd.step)
        STEP_INIT, STEP_CLR: begin
          spare <= ~(DESCRIPTORS'(1) << fs);
          fh    <= LINK_W'(fs);
          lh    <= NIL;
          lt    <= '0;
        end
        STEP_IDLE: begin
          if (cfg_we && (cfg_reg_t'(cfg_index) == CFG_CELL)) cs <= cfg_data[CELL_W-1:0];
          if (cfg_total) begin
            ts    <= OFF_W'(cfg_data);
            spare <= ~(DESCRIPTORS'(1) << fs);
            fh    <= LINK_W'(fs);
            lh    <= NIL;
            lt    <= '0;
          end
        end
        STEP_DECODE: merged <= 1'b0;
        STEP_A_CHK: begin
          if (sts.fit && !sts.exact && !sts.no_spare) spare[spare_idx] <= 1'b0;
        end
        STEP_X_P_RD: if (ecur.lprev == NIL) fh <= ecur.lnext;
        STEP_X_E_WR: begin
          lh <= LINK_W'(eidx);
          lt <= lt + size[OFF_W-1:0];
        end
        STEP_S_P_RD: if (ecur.aprev == NIL) fs <= d;
        STEP_S_D_WR: begin
          lh <= LINK_W'(d);
          lt <= lt + size[OFF_W-1:0];
        end
        STEP_F_CHK: if (sts.hit) lt <= lt - rdata.length;
        STEP_F_P_RD: if (ecur.lprev == NIL) lh <= ecur.lnext;
        STEP_F_AP_CHK: begin
          if (rdata.free) begin
            spare[eidx] <= 1'b1;
            merged      <= 1'b1;
          end
        end
        STEP_F_UP_RD: if (ecur.lprev == NIL) fh <= ecur.lnext;
        STEP_F_Q_RD: if (ecur.aprev == NIL) fs <= nidx;
        STEP_F_M_WR: spare[eidx] <= 1'b1;
        STEP_F_E_WR: if (!merged) fh <= LINK_W'(eidx);
        default: begin
          merged <= merged;
        end
      endcase
    end
  end

  // Item, walk and result registers.
  always_ff @(posedge clk) begin
    unique case (cmd.step)
      STEP_IDLE: begin
        if (in_accept) begin
          op    <= op_t'(in_op);
          rsize <= in_request_size;
          roff  <= in_release_offset;
        end
      end
      STEP_DECODE: begin
        res_status <= (op == OP_ALLOC && rsize == '0) ? STAT_ZERO :
                      (op == OP_FREE && roff > ts)    ? STAT_RANGE : STAT_OK;
        res_off    <= '0;
        res_sz     <= '0;
        rem        <= '0;
        cnt        <= CNT_W'(OFF_W - 1);
      end
      STEP_DIV: begin
        rem <= rem_next;
        cnt <= cnt - CNT_W'(1);
      end
      STEP_A_RD: begin
        size  <= size_calc;
        cur   <= fh;
        steps <= '0;
        if (fh == NIL) res_status <= STAT_NOFIT;
      end
      STEP_A_CHK: begin
        if (sts.fit) begin
          ecur <= rdata;
          eidx <= cur[ADDR_W-1:0];
          d    <= spare_idx;
          if (!sts.exact && sts.no_spare) res_status <= STAT_NODESC;
        end else begin
          cur   <= rdata.lnext;
          steps <= steps + ADDR_W'(1);
          if (walk_end) res_status <= STAT_NOFIT;
        end
      end
      STEP_X_E_WR: begin
        res_off <= ecur.offset;
        res_sz  <= size[OFF_W-1:0];
      end
      STEP_S_D_WR: begin
        res_off <= ecur.offset;
        res_sz  <= size[OFF_W-1:0];
      end
      STEP_F_RD: begin
        cur   <= lh;
        steps <= '0;
        if (lh == NIL) res_status <= STAT_NOTALLOC;
      end
      STEP_F_CHK: begin
        if (sts.hit) begin
          ecur   <= rdata;
          eidx   <= cur[ADDR_W-1:0];
          res_sz <= rdata.length;
        end else begin
          cur   <= rdata.lnext;
          steps <= steps + ADDR_W'(1);
          if (walk_end) res_status <= STAT_NOTALLOC;
        end
      end
      STEP_F_AP_CHK: begin
        // absorb the freed block into its free lower neighbor
        if (rdata.free) begin
          ecur <= '{offset: rdata.offset, length: rdata.length + ecur.length,
                    free: rdata.free, aprev: rdata.aprev, anext: ecur.anext,
                    lprev: rdata.lprev, lnext: rdata.lnext};
          eidx <= ecur.aprev[ADDR_W-1:0];
        end
      end
      STEP_F_NX_CHK: nidx <= ecur.anext[ADDR_W-1:0];
      STEP_RESP: begin
        if (out_free) begin
          out_status       <= res_status;
          out_grant_offset <= (res_status == STAT_OK) ? res_off : '0;
          out_granted_size <= (res_status == STAT_OK) ? res_sz : '0;
          out_locked_bytes <= lt;
        end
      end
      default: begin
        cur <= cur;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/first_fit_allocator_coalescing.sv */
// Allocate rounds the size, walks the free list and then relinks; free walks the
// locked list, then relinks and merges free neighbours; clear rebuilds the table.
// One item is in work at a time, set by the one-read, one-write descriptor
// memory and the 24-step size rounding.
// Reset: synchronous; the initialisation state after rst makes the region one free segment.
`default_nettype none
module first_fit_allocator_coalescing (
  input  logic                             clk,
  input  logic                             rst,
  ffa_req_if.sink                          req,
  ffa_rsp_if.source                        rsp,
  input  logic                             cfg_we,
  input  logic [ffa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ffa_pkg::CFG_W-1:0]        cfg_data
);
  import ffa_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_accept;

  assign req.ready = (cmd.step == STEP_IDLE);
  assign in_accept = req.valid && req.ready;

  ffa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffa_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .in_accept         (in_accept),
    .in_op             (req.op),
    .in_request_size   (req.request_size),
    .in_release_offset (req.release_offset),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (rsp.valid),
    .out_ready         (rsp.ready),
    .out_status        (rsp.status),
    .out_grant_offset  (rsp.grant_offset),
    .out_granted_size  (rsp.granted_size),
    .out_locked_bytes  (rsp.locked_bytes)
  );

endmodule
`default_nettype wire

/* tb/tb_first_fit_allocator_coalescing.sv */
`timescale 1ns / 1ps
`default_nettype none

class alloc_scoreboard;
  localparam int ND  = ffa_pkg::DESCRIPTORS;
  localparam int NIL = ffa_pkg::DESCRIPTORS;
  localparam longint MASK = 64'hFFFFFF;

  typedef struct {
    ffa_pkg::status_t st;
    logic [23:0] go;
    logic [23:0] gs;
    logic [23:0] lb;
  } outcome_t;

  logic [12:0] gran;
  logic [23:0] total;
  longint seg_off[ND];
  longint seg_len[ND];
  bit is_free[ND];
  bit spare[ND];
  int ap[ND], an[ND], lp[ND], ln[ND];
  int heads[2];  // 0: free list, 1: locked list
  int first_seg;
  longint locked;
  outcome_t outcomes[$];
  int errors;
  int checked;
  int sent;

  function void wipe();
    int f;
    f = (first_seg < NIL) ? first_seg : 0;
    for (int i = 0; i < ND; i++) begin
      spare[i] = (i != f);
      seg_off[i] = 0; seg_len[i] = 0; is_free[i] = 0;
      ap[i] = NIL; an[i] = NIL; lp[i] = NIL; ln[i] = NIL;
    end
    seg_len[f] = total;
    is_free[f] = 1;
    first_seg = f;
    heads[0] = f;
    heads[1] = NIL;
    locked = 0;
  endfunction

  function void reset_state();
    gran = ffa_pkg::CELL_RESET;
    total = ffa_pkg::TOTAL_RESET;
    first_seg = 0;
    wipe();
  endfunction

  function void write_reg(ffa_pkg::cfg_reg_t idx, logic [23:0] v);
    if (idx == ffa_pkg::CFG_CELL) gran = v[12:0];
    else begin
      total = v;
      wipe();
    end
  endfunction

  function void unlink(int h, int d);
    int p, n;
    p = lp[d]; n = ln[d];
    if (p < NIL) ln[p] = n; else heads[h] = n;
    if (n < NIL) lp[n] = p;
    lp[d] = NIL; ln[d] = NIL;
  endfunction

  function void push(int h, int d);
    lp[d] = NIL;
    ln[d] = heads[h];
    if (heads[h] < NIL) lp[heads[h]] = d;
    heads[h] = d;
  endfunction

  function ffa_pkg::status_t grant(longint req, output longint go, output longint gs);
    longint cs, rem, size;
    int e, d, p;
    go = 0; gs = 0;
    cs = (gran != 0) ? gran : 1;
    if (req == 0) return ffa_pkg::STAT_ZERO;
    rem = req % cs;
    size = rem ? req + (cs - rem) : req;
    e = heads[0];
    for (int steps = 0; e < NIL && steps < ND; steps++) begin
      if (seg_len[e] >= size) begin
        if (seg_len[e] == size) begin
          unlink(0, e);
          is_free[e] = 0;
          push(1, e);
          locked = (locked + size) & MASK;
          go = seg_off[e]; gs = size;
          return ffa_pkg::STAT_OK;
        end
        d = 0;
        while (d < ND && !spare[d]) d++;
        if (d >= ND) return ffa_pkg::STAT_NODESC;
        spare[d] = 0;
        p = ap[e];
        ap[d] = p; an[d] = e;
        if (p < NIL) an[p] = d; else first_seg = d;
        ap[e] = d;
        seg_off[d] = seg_off[e];
        seg_len[d] = size;
        seg_off[e] = (seg_off[e] + size) & MASK;
        seg_len[e] -= size;
        is_free[d] = 0;
        push(1, d);
        locked = (locked + size) & MASK;
        go = seg_off[d]; gs = size;
        return ffa_pkg::STAT_OK;
      end
      e = ln[e];
    end
    return ffa_pkg::STAT_NOFIT;
  endfunction

  function ffa_pkg::status_t release_block(longint where, output longint gs);
    int e, steps, p, n;
    bit merged;
    gs = 0;
    merged = 0;
    if (where > total) return ffa_pkg::STAT_RANGE;
    e = heads[1];
    for (steps = 0; e < NIL && steps < ND; steps++) begin
      if (seg_off[e] == where) break;
      e = ln[e];
    end
    if (e >= NIL || steps >= ND) return ffa_pkg::STAT_NOTALLOC;
    unlink(1, e);
    gs = seg_len[e];
    locked = (locked - seg_len[e]) & MASK;
    is_free[e] = 1;
    p = ap[e];
    if (p < NIL && is_free[p]) begin
      n = an[e];
      an[p] = n;
      if (n < NIL) ap[n] = p;
      seg_len[p] = (seg_len[p] + seg_len[e]) & MASK;
      spare[e] = 1; is_free[e] = 0;
      e = p;
      merged = 1;
    end
    n = an[e];
    if (n < NIL && is_free[n]) begin
      if (merged) unlink(0, e);
      p = ap[e];
      ap[n] = p;
      if (p < NIL) an[p] = n; else first_seg = n;
      seg_len[n] = (seg_len[n] + seg_len[e]) & MASK;
      seg_off[n] = seg_off[e];
      spare[e] = 1; is_free[e] = 0;
      merged = 1;
    end
    if (!merged) push(0, e);
    return ffa_pkg::STAT_OK;
  endfunction

  // Predict the response for one accepted request.
  function void note(ffa_pkg::op_t op, logic [23:0] rs, logic [23:0] ro);
    outcome_t o;
    longint go, gs;
    go = 0; gs = 0;
    o.st = ffa_pkg::STAT_OK;
    case (op)
      ffa_pkg::OP_ALLOC: o.st = grant(rs, go, gs);
      ffa_pkg::OP_FREE: begin
        o.st = release_block(ro, gs);
        go = 0;
      end
      ffa_pkg::OP_CLEAR: wipe();
      default: ;
    endcase
    if (o.st != ffa_pkg::STAT_OK) begin
      go = 0; gs = 0;
    end
    o.go = go[23:0];
    o.gs = gs[23:0];
    o.lb = locked[23:0];
    outcomes.push_back(o);
    sent++;
  endfunction

  function void mismatch(string field, longint e, longint a);
    errors++;
    if (errors <= 30)
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, e, a);
  endfunction

  function void check(logic [2:0] st, logic [23:0] go, logic [23:0] gs, logic [23:0] lb);
    outcome_t o;
    checked++;
    if (outcomes.size() == 0) begin
      mismatch("unexpected response status", -1, st);
      return;
    end
    o = outcomes.pop_front();
    if (st !== o.st) mismatch("status", o.st, st);
    if (go !== o.go) mismatch("grant_offset", o.go, go);
    if (gs !== o.gs) mismatch("granted_size", o.gs, gs);
    if (lb !== o.lb) mismatch("locked_bytes", o.lb, lb);
  endfunction

  // Offset of a random locked block, or a random in-range value if none.
  function logic [23:0] some_locked();
    longint offs[$];
    int e;
    e = heads[1];
    for (int s = 0; e < NIL && s < ND; s++) begin
      offs.push_back(seg_off[e]);
      e = ln[e];
    end
    if (offs.size() == 0) return 24'($urandom_range(total));
    return 24'(offs[$urandom_range(offs.size() - 1)]);
  endfunction
endclass

module tb_first_fit_allocator_coalescing;
  import ffa_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  int sender_idle = 0;
  int receiver_stall = 0;
  int quiet_cycles = 0;
  int settings_run = 0;
  alloc_scoreboard sb = new();

  ffa_req_if req_ch();
  ffa_rsp_if rsp_ch();

  first_fit_allocator_coalescing i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    req_ch.valid = 0;
    req_ch.op = OP_NOP;
    req_ch.request_size = '0;
    req_ch.release_offset = '0;
    rsp_ch.ready = 0;
  end

  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= receiver_stall);
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check(rsp_ch.status, rsp_ch.grant_offset, rsp_ch.granted_size,
               rsp_ch.locked_bytes);
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == 5000) begin
      $display("Watchdog expired with %0d responses outstanding", sb.outcomes.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send(op_t op, logic [23:0] rs, logic [23:0] ro);
    while ($urandom_range(99) < sender_idle) begin
      req_ch.valid <= 0;
      @(posedge clk);
    end
    req_ch.valid <= 1;
    req_ch.op <= op;
    req_ch.request_size <= rs;
    req_ch.release_offset <= ro;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note(op, rs, ro);
  endtask

  task automatic drain();
    req_ch.valid <= 0;
    while (sb.outcomes.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [23:0] v);
    drain();
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, v);
    settings_run++;
  endtask

  task automatic random_items(int count);
    int pick, alloc_pct;
    logic [23:0] rs, ro;
    op_t op;
    for (int k = 0; k < count; k++) begin
      case ((k / 60) % 4)
        0: begin sender_idle = 0;  receiver_stall = 0;  end
        1: begin sender_idle = 57; receiver_stall = 0;  end
        2: begin sender_idle = 0;  receiver_stall = 57; end
        default: begin sender_idle = 38; receiver_stall = 38; end
      endcase
      // alternate alloc-heavy and free-heavy stretches to reach exhaustion and merging
      alloc_pct = ((k / 100) % 2 == 0) ? 75 : 40;
      pick = $urandom_range(99);
      rs = 24'($urandom);
      ro = 24'($urandom);
      if (pick < alloc_pct) begin
        op = OP_ALLOC;
        pick = $urandom_range(99);
        if (pick < 85) rs = 24'($urandom_range(1, (sb.total >> 5) + 1));
        else if (pick < 90) rs = 0;
        else if (pick < 95) rs = sb.total;
      end else if (pick < 95) begin
        op = OP_FREE;
        pick = $urandom_range(99);
        if (pick < 70) ro = sb.some_locked();
        else if (pick < 80) ro = sb.some_locked() + 24'd1;
        else if (pick < 90) ro = 24'($urandom_range(sb.total));
      end else if (pick < 98) begin
        op = OP_CLEAR;
      end else begin
        op = OP_NOP;
      end
      send(op, rs, ro);
    end
  endtask

  initial begin
    sb.reset_state();
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send(OP_ALLOC, 24'd0, 24'd0);
    send(OP_ALLOC, 24'd1, 24'd0);
    send(OP_ALLOC, 24'd16, 24'd0);
    send(OP_ALLOC, 24'd17, 24'd0);
    send(OP_ALLOC, 24'hFFFFFF, 24'hFFFFFF);
    send(OP_ALLOC, 24'd65472, 24'd0);
    send(OP_ALLOC, 24'd1, 24'd0);
    send(OP_FREE, 24'd0, 24'd16);
    send(OP_FREE, 24'd0, 24'd0);
    send(OP_FREE, 24'd0, 24'd32);
    send(OP_FREE, 24'd0, 24'd65536);
    send(OP_FREE, 24'd0, 24'd65537);
    send(OP_FREE, 24'd0, 24'hFFFFFF);
    send(OP_FREE, 24'd0, 24'd5);
    send(OP_NOP, 24'hFFFFFF, 24'hFFFFFF);
    send(OP_ALLOC, 24'd100, 24'd0);
    send(OP_CLEAR, 24'd0, 24'd0);
    send(OP_FREE, 24'd0, 24'd0);
    write_reg(CFG_CELL, 24'd0);
    send(OP_ALLOC, 24'd3, 24'd0);
    send(OP_ALLOC, 24'd65533, 24'd0);

    random_items(300);
    write_reg(CFG_CELL, 24'd1);
    write_reg(CFG_TOTAL, 24'd1000);
    random_items(300);
    write_reg(CFG_CELL, 24'd4096);
    write_reg(CFG_TOTAL, 24'hFFFFFF);
    random_items(300);
    write_reg(CFG_CELL, 24'd8191);
    write_reg(CFG_TOTAL, 24'd1);
    random_items(150);
    write_reg(CFG_CELL, 24'd0);
    write_reg(CFG_TOTAL, 24'd777);
    random_items(300);
    write_reg(CFG_CELL, 24'd16);
    write_reg(CFG_TOTAL, 24'd65536);
    random_items(480);

    drain();
    $display("Sent %0d requests and checked %0d responses across %0d register writes",
             sb.sent, sb.checked, settings_run);
    $display("Covered allocate, free, clear and idle opcodes under four idling modes");
    if (sb.errors == 0 && sb.outcomes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

`default_nettype wire
